// ===== hw/rtl/handshake_greeting_parser_macros.svh =====
// Assertion macros for the greeting parser checker.
`ifndef HANDSHAKE_GREETING_PARSER_MACROS_SVH
`define HANDSHAKE_GREETING_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define GHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define GHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ghp_pkg.sv =====
package ghp_pkg;

  localparam int unsigned NAME_LEN   = 21;
  localparam int unsigned NAME_IDX_W = 5;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [8*NAME_LEN-1:0] PLUGIN_NAME =
      168'h6d7973716c5f6e61746976655f70617373776f7264;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_VER   = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
  localparam logic [1:0] STATUS_BAD_PLUG  = 2'd3;

  localparam logic KIND_SCRAMBLE = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  localparam int unsigned CAP_SECURE_BIT = 15;
  localparam int unsigned CAP_PLUGIN_BIT = 19;

  localparam logic [0:0] REG_EXPECTED_VERSION = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  scramble_byte;
    logic [4:0]  scramble_index;
    logic [1:0]  status;
    logic [7:0]  version_seen;
    logic [31:0] session_id;
    logic [31:0] capabilities;
    logic        scramble_ok;
    logic [4:0]  scramble_count;
    logic        run_end;
  } out_res_t;

  typedef struct packed {
    logic        has_scr;
    logic [7:0]  scr_byte;
    logic [4:0]  scr_index;
    logic        has_sum;
    logic [1:0]  status;
    logic [7:0]  version;
    logic [31:0] conn_id;
    logic [31:0] caps;
    logic        scr_ok;
    logic [4:0]  scr_count;
  } entry_t;

  function automatic logic [7:0] plugin_char(input logic [NAME_IDX_W-1:0] idx);
    logic [7:0] c;
    c = '0;
    if (idx < NAME_IDX_W'(NAME_LEN)) begin
      c = PLUGIN_NAME[8*(NAME_LEN-1-int'(idx)) +: 8];
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ghp_front.sv =====
module ghp_front #(
  parameter int unsigned SCRAMBLE_MAX = 20,
  parameter int unsigned PART_TWO_MIN = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ghp_pkg::in_req_t req_i,
  input  logic [7:0]       expected_version_i,
  output logic             entry_valid_o,
  output ghp_pkg::entry_t  entry_o
);

  localparam int unsigned SEEN_W =
      ($clog2(SCRAMBLE_MAX + 1) > 5) ? $clog2(SCRAMBLE_MAX + 1) : 5;
  localparam int unsigned NW = ghp_pkg::NAME_IDX_W;

  localparam logic [3:0] PH_VER      = 4'd0;
  localparam logic [3:0] PH_VTEXT    = 4'd1;
  localparam logic [3:0] PH_CONN     = 4'd2;
  localparam logic [3:0] PH_PART1    = 4'd3;
  localparam logic [3:0] PH_FILL     = 4'd4;
  localparam logic [3:0] PH_CAPLO    = 4'd5;
  localparam logic [3:0] PH_CHST     = 4'd6;
  localparam logic [3:0] PH_CAPHI    = 4'd7;
  localparam logic [3:0] PH_ALEN     = 4'd8;
  localparam logic [3:0] PH_RSV      = 4'd9;
  localparam logic [3:0] PH_PART2    = 4'd10;
  localparam logic [3:0] PH_NAME     = 4'd11;
  localparam logic [3:0] PH_NAMEDONE = 4'd12;
  localparam logic [3:0] PH_NONAME   = 4'd13;
  localparam logic [3:0] PH_BADVER   = 4'd14;

  logic [3:0]        phase_q, phase_d;
  logic [7:0]        fc_q, fc_d;
  logic [7:0]        ver_q, ver_d;
  logic [31:0]       conn_q, conn_d;
  logic [31:0]       caps_q, caps_d;
  logic [7:0]        p2len_q, p2len_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic              sflag_q, sflag_d;
  logic [NW-1:0]     nidx_q, nidx_d;
  logic              nmatch_q, nmatch_d;

  logic [7:0] b;
  logic [7:0] fc_inc;
  logic [7:0] alen;
  logic [7:0] adiff;
  logic [7:0] pmin;
  logic       emit;
  logic [1:0] status;
  logic       chst_ok;
  logic [3:0] after_fixed;

  assign b           = req_i.data_byte;
  assign fc_inc      = fc_q + 8'd1;
  assign pmin        = 8'(PART_TWO_MIN);
  assign alen        = caps_q[ghp_pkg::CAP_PLUGIN_BIT] ? b : 8'd0;
  assign adiff       = (alen > 8'd8) ? (alen - 8'd8) : 8'd0;
  assign after_fixed = caps_q[ghp_pkg::CAP_PLUGIN_BIT] ? PH_NAME : PH_NONAME;
  assign emit        = ((phase_q == PH_PART1) || (phase_q == PH_PART2)) &&
                       (seen_q < SEEN_W'(SCRAMBLE_MAX));

  always_comb begin
    phase_d  = phase_q;
    fc_d     = fc_q;
    ver_d    = ver_q;
    conn_d   = conn_q;
    caps_d   = caps_q;
    p2len_d  = p2len_q;
    sflag_d  = sflag_q;
    nidx_d   = nidx_q;
    nmatch_d = nmatch_q;
    seen_d   = emit ? (seen_q + SEEN_W'(1)) : seen_q;
    case (phase_q)
      PH_VER: begin
        ver_d   = b;
        phase_d = (b != expected_version_i) ? PH_BADVER : PH_VTEXT;
      end
      PH_VTEXT: begin
        if (b == 8'd0) begin
          phase_d = PH_CONN;
          fc_d    = '0;
        end
      end
      PH_CONN: begin
        conn_d[{fc_q[1:0], 3'b000} +: 8] = conn_q[{fc_q[1:0], 3'b000} +: 8] | b;
        fc_d = fc_inc;
        if (fc_inc >= 8'd4) begin
          phase_d = PH_PART1;
          fc_d    = '0;
        end
      end
      PH_PART1: begin
        fc_d = fc_inc;
        if (fc_inc >= 8'd8) begin
          phase_d = PH_FILL;
          fc_d    = '0;
        end
      end
      PH_FILL: begin
        phase_d = PH_CAPLO;
        fc_d    = '0;
      end
      PH_CAPLO: begin
        caps_d[{fc_q[0], 3'b000} +: 8] = caps_q[{fc_q[0], 3'b000} +: 8] | b;
        fc_d = fc_inc;
        if (fc_inc >= 8'd2) begin
          phase_d = PH_CHST;
          fc_d    = '0;
        end
      end
      PH_CHST: begin
        fc_d = fc_inc;
        if (fc_inc >= 8'd3) begin
          phase_d = PH_CAPHI;
          fc_d    = '0;
        end
      end
      PH_CAPHI: begin
        caps_d[{1'b1, fc_q[0], 3'b000} +: 8] = caps_q[{1'b1, fc_q[0], 3'b000} +: 8] | b;
        fc_d = fc_inc;
        if (fc_inc >= 8'd2) begin
          phase_d = PH_ALEN;
          fc_d    = '0;
        end
      end
      PH_ALEN: begin
        p2len_d = (adiff > pmin) ? adiff : pmin;
        phase_d = PH_RSV;
        fc_d    = '0;
      end
      PH_RSV: begin
        fc_d = fc_inc;
        if (fc_inc >= 8'd10) begin
          fc_d    = '0;
          phase_d = caps_q[ghp_pkg::CAP_SECURE_BIT] ? PH_PART2 : after_fixed;
        end
      end
      PH_PART2: begin
        fc_d = fc_inc;
        if (fc_inc >= p2len_q) begin
          fc_d    = '0;
          sflag_d = 1'b1;
          phase_d = after_fixed;
        end
      end
      PH_NAME: begin
        if (b == 8'd0) begin
          phase_d = PH_NAMEDONE;
        end else if ((nidx_q < NW'(ghp_pkg::NAME_LEN)) &&
                     (b == ghp_pkg::plugin_char(nidx_q))) begin
          nidx_d = nidx_q + NW'(1);
        end else begin
          nmatch_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    chst_ok = 1'b0;
    case (phase_d)
      PH_BADVER: status = ghp_pkg::STATUS_BAD_VER;
      PH_CHST: begin
        if (fc_d == 8'd0) begin
          chst_ok = 1'b1;
          status  = ghp_pkg::STATUS_OK;
        end else begin
          status  = ghp_pkg::STATUS_TRUNCATED;
        end
      end
      PH_NAME, PH_NAMEDONE: begin
        status = (nmatch_d && (nidx_d == NW'(ghp_pkg::NAME_LEN))) ?
                 ghp_pkg::STATUS_OK : ghp_pkg::STATUS_BAD_PLUG;
      end
      PH_NONAME: status = ghp_pkg::STATUS_BAD_PLUG;
      default:   status = ghp_pkg::STATUS_TRUNCATED;
    endcase
  end

  always_comb begin
    entry_o.has_scr   = emit;
    entry_o.scr_byte  = b;
    entry_o.scr_index = seen_q[4:0];
    entry_o.has_sum   = req_i.end_of_packet;
    entry_o.status    = status;
    entry_o.version   = ver_d;
    entry_o.conn_id   = conn_d;
    entry_o.caps      = caps_d;
    entry_o.scr_ok    = sflag_d | chst_ok;
    entry_o.scr_count = seen_d[4:0];
  end

  assign entry_valid_o = valid_i && (emit || req_i.end_of_packet);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_VER;
      fc_q     <= '0;
      ver_q    <= '0;
      conn_q   <= '0;
      caps_q   <= '0;
      p2len_q  <= '0;
      seen_q   <= '0;
      sflag_q  <= 1'b0;
      nidx_q   <= '0;
      nmatch_q <= 1'b1;
    end else if (valid_i) begin
      if (req_i.end_of_packet) begin
        phase_q  <= PH_VER;
        fc_q     <= '0;
        ver_q    <= '0;
        conn_q   <= '0;
        caps_q   <= '0;
        p2len_q  <= '0;
        seen_q   <= '0;
        sflag_q  <= 1'b0;
        nidx_q   <= '0;
        nmatch_q <= 1'b1;
      end else begin
        phase_q  <= phase_d;
        fc_q     <= fc_d;
        ver_q    <= ver_d;
        conn_q   <= conn_d;
        caps_q   <= caps_d;
        p2len_q  <= p2len_d;
        seen_q   <= seen_d;
        sflag_q  <= sflag_d;
        nidx_q   <= nidx_d;
        nmatch_q <= nmatch_d;
      end
    end
  end

endmodule

// ===== hw/rtl/ghp_fifo.sv =====
module ghp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  ghp_pkg::entry_t wr_data_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output ghp_pkg::entry_t rd_data_o,
  output logic            empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ghp_pkg::entry_t slots_q [DEPTH];

  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          do_wr, do_rd;

  assign full_o    = (count_q == CW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ghp_back.sv =====
module ghp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ghp_pkg::entry_t   entry_i,
  input  logic              entry_empty_i,
  output logic              entry_pop_o,
  output logic              res_valid_o,
  output ghp_pkg::out_res_t res_o,
  input  logic              res_pop_i
);

  logic              valid_q, valid_d;
  logic              scr_done_q, scr_done_d;
  ghp_pkg::out_res_t res_q, res_d;
  logic              load;
  logic              take_scr;

  assign load     = !valid_q || res_pop_i;
  assign take_scr = entry_i.has_scr && !scr_done_q;

  always_comb begin
    valid_d     = valid_q;
    scr_done_d  = scr_done_q;
    res_d       = res_q;
    entry_pop_o = 1'b0;
    if (load) begin
      valid_d = !entry_empty_i;
      if (!entry_empty_i) begin
        res_d = '0;
        if (take_scr) begin
          res_d.kind           = ghp_pkg::KIND_SCRAMBLE;
          res_d.scramble_byte  = entry_i.scr_byte;
          res_d.scramble_index = entry_i.scr_index;
          res_d.run_end        = !entry_i.has_sum;
          scr_done_d           = entry_i.has_sum;
          entry_pop_o          = !entry_i.has_sum;
        end else begin
          res_d.kind           = ghp_pkg::KIND_SUMMARY;
          res_d.status         = entry_i.status;
          res_d.version_seen   = entry_i.version;
          res_d.session_id     = entry_i.conn_id;
          res_d.capabilities   = entry_i.caps;
          res_d.scramble_ok    = entry_i.scr_ok;
          res_d.scramble_count = entry_i.scr_count;
          res_d.run_end        = 1'b1;
          scr_done_d           = 1'b0;
          entry_pop_o          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      scr_done_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      scr_done_q <= scr_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/handshake_greeting_parser.sv =====
// Parses the payload of a protocol v10 server greeting, one byte per request, and returns
// one scramble result per scramble byte (at most SCRAMBLE_MAX) plus a summary result on
// the byte marked end_of_packet. A byte is taken in every cycle in which push is high and
// full is low; the parser state updates in that same cycle, so the input side runs at one
// byte per clock while full is low. Results pass through a FIFO_DEPTH-entry queue and then
// a one-result output register, which drives the output. The output stage sends one result
// per cycle while pop is high; a byte with both a scramble byte and the end mark yields two
// results, scramble first. full rises only when the queue backs up behind a stalled consumer.
// No clearing pass follows reset. expected_version is written through the APB port at byte
// address 0 (paddr bit 2 low) by the user, only while idle; the block does not enforce this.
module handshake_greeting_parser #(
  parameter int unsigned SCRAMBLE_MAX = 20,
  parameter int unsigned PART_TWO_MIN = 13,
  parameter int unsigned FIFO_DEPTH   = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  ghp_pkg::in_req_t                   req_i,
  output logic                               empty,
  input  logic                               pop,
  output ghp_pkg::out_res_t                  res_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ghp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ghp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ghp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic            ver_wr;
  logic [7:0]      expected_version_q;
  logic            accept;
  logic            entry_valid;
  ghp_pkg::entry_t entry_wr;
  ghp_pkg::entry_t entry_rd;
  logic            entry_empty;
  logic            entry_pop;
  logic            res_valid;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ghp_pkg::CFG_ADDR_W-1] == ghp_pkg::REG_EXPECTED_VERSION);
  assign prdata  = reg_sel ? {24'd0, expected_version_q} : '0;
  assign ver_wr  = psel && penable && pwrite && pready && reg_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_version_q <= 8'd10;
    end else if (ver_wr) begin
      expected_version_q <= pwdata[7:0];
    end
  end

  assign accept = push && !full;

  ghp_front #(
    .SCRAMBLE_MAX (SCRAMBLE_MAX),
    .PART_TWO_MIN (PART_TWO_MIN)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (accept),
    .req_i              (req_i),
    .expected_version_i (expected_version_q),
    .entry_valid_o      (entry_valid),
    .entry_o            (entry_wr)
  );

  ghp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (entry_valid),
    .wr_data_i (entry_wr),
    .full_o    (full),
    .rd_en_i   (entry_pop),
    .rd_data_o (entry_rd),
    .empty_o   (entry_empty)
  );

  ghp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (entry_rd),
    .entry_empty_i (entry_empty),
    .entry_pop_o   (entry_pop),
    .res_valid_o   (res_valid),
    .res_o         (res_o),
    .res_pop_i     (pop)
  );

  assign empty = !res_valid;

endmodule

// ===== hw/rtl/ghp_checker.sv =====
`include "handshake_greeting_parser_macros.svh"

module ghp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           empty,
  input logic                           pop,
  input ghp_pkg::out_res_t              res_o,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [ghp_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [ghp_pkg::CFG_DATA_W-1:0] pwdata,
  input logic [ghp_pkg::CFG_DATA_W-1:0] prdata,
  input logic                           pready
);

  logic       summary_shown;
  logic       scramble_shown;
  logic       scr_clean;
  logic       ver_wr;
  logic       hi_addr;
  logic [7:0] rd_ver;
  logic [7:0] wd_ver;

  assign summary_shown  = !empty && (res_o.kind == ghp_pkg::KIND_SUMMARY);
  assign scramble_shown = !empty && (res_o.kind == ghp_pkg::KIND_SCRAMBLE);
  assign scr_clean      = (res_o.status == ghp_pkg::STATUS_OK) && (res_o.session_id == '0) &&
                          (res_o.capabilities == '0) && !res_o.scramble_ok;
  assign hi_addr        = paddr[ghp_pkg::CFG_ADDR_W-1];
  assign ver_wr         = psel && penable && pwrite && pready &&
                          (hi_addr == ghp_pkg::REG_EXPECTED_VERSION);
  assign rd_ver         = prdata[7:0];
  assign wd_ver         = pwdata[7:0];

  `GHP_ASSERT_NOW(a_summary_ends_run, summary_shown, res_o.run_end, "summary without run end")
  `GHP_ASSERT_NOW(a_scramble_clean, scramble_shown, scr_clean, "summary fields in scramble result")
  `GHP_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(res_o), "waiting result changed")
  `GHP_ASSERT_NEXT(a_ver_readback, ver_wr, hi_addr || (rd_ver == $past(wd_ver)), "version lost")

endmodule

bind handshake_greeting_parser ghp_checker u_checker (.*);

// ===== tb/handshake_greeting_parser_test.sv =====
module handshake_greeting_parser_test;

  localparam int unsigned SCRAMBLE_LIMIT = 20;
  localparam int unsigned PART_TWO_FLOOR = 13;
  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef enum logic [3:0] {
    PH_VERSION, PH_VER_TEXT, PH_CONN_ID, PH_SCR_ONE, PH_FILLER, PH_CAPS_LO,
    PH_CHARSET_STATUS, PH_CAPS_HI, PH_AUTH_LEN, PH_RESERVED, PH_SCR_TWO,
    PH_PLUGIN, PH_PLUGIN_DONE, PH_NO_PLUGIN, PH_BAD_VERSION
  } parse_phase_e;

  typedef struct packed {
    ghp_pkg::in_req_t  item;
    logic              typed;
    ghp_pkg::out_res_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push;
  logic full;
  ghp_pkg::in_req_t req_i;
  logic empty;
  logic pop;
  ghp_pkg::out_res_t res_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ghp_pkg::CFG_ADDR_W-1:0] paddr;
  logic [ghp_pkg::CFG_DATA_W-1:0] pwdata;
  logic [ghp_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  parse_phase_e parse_phase;
  logic [7:0] field_cnt;
  logic [7:0] version_byte;
  logic [31:0] conn_id;
  logic [31:0] cap_word;
  logic [7:0] part_two_bytes;
  logic [4:0] scr_emitted;
  logic scr_complete;
  logic [4:0] name_pos;
  logic name_intact;
  logic [7:0] version_cfg;

  ghp_pkg::out_res_t byte_results[$];
  ghp_pkg::out_res_t expected_parse_results[$];
  logic [7:0] packet_bytes[$];

  int mismatch_count = 0;
  int idle_pct;
  int stall_pct;
  bit hold_request;

  handshake_greeting_parser #(
    .SCRAMBLE_MAX(SCRAMBLE_LIMIT),
    .PART_TWO_MIN(PART_TWO_FLOOR)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .req_i(req_i),
    .empty(empty),
    .pop(pop),
    .res_o(res_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic ghp_pkg::out_res_t summary(input logic [1:0] st, input logic [7:0] ver,
                                                input logic [31:0] conn,
                                                input logic [31:0] caps,
                                                input logic ok, input logic [4:0] cnt);
    ghp_pkg::out_res_t r;
    r = '0;
    r.kind = ghp_pkg::KIND_SUMMARY;
    r.status = st;
    r.version_seen = ver;
    r.session_id = conn;
    r.capabilities = caps;
    r.scramble_ok = ok;
    r.scramble_count = cnt;
    r.run_end = 1'b1;
    return r;
  endfunction

  task automatic reset_parse();
    parse_phase = PH_VERSION;
    field_cnt = '0;
    version_byte = '0;
    conn_id = '0;
    cap_word = '0;
    part_two_bytes = '0;
    scr_emitted = '0;
    scr_complete = 1'b0;
    name_pos = '0;
    name_intact = 1'b1;
  endtask

  task automatic emit_scramble(input logic [7:0] b);
    ghp_pkg::out_res_t r;
    if (scr_emitted < SCRAMBLE_LIMIT) begin
      r = '0;
      r.kind = ghp_pkg::KIND_SCRAMBLE;
      r.scramble_byte = b;
      r.scramble_index = scr_emitted;
      byte_results.insert(byte_results.size(), r);
      scr_emitted++;
    end
  endtask

  task automatic parse_greeting_byte(input ghp_pkg::in_req_t item);
    logic [7:0] b;
    logic [7:0] alen;
    logic [7:0] d;
    logic [1:0] st;
    b = item.data_byte;
    byte_results.delete();
    case (parse_phase)
      PH_VERSION: begin
        version_byte = b;
        parse_phase = (b != version_cfg) ? PH_BAD_VERSION : PH_VER_TEXT;
      end
      PH_VER_TEXT: begin
        if (b == 8'h00) begin
          parse_phase = PH_CONN_ID;
          field_cnt = '0;
        end
      end
      PH_CONN_ID: begin
        conn_id |= 32'(b) << (8 * field_cnt[1:0]);
        field_cnt++;
        if (field_cnt >= 4) begin
          parse_phase = PH_SCR_ONE;
          field_cnt = '0;
        end
      end
      PH_SCR_ONE: begin
        emit_scramble(b);
        field_cnt++;
        if (field_cnt >= 8) begin
          parse_phase = PH_FILLER;
          field_cnt = '0;
        end
      end
      PH_FILLER: begin
        parse_phase = PH_CAPS_LO;
        field_cnt = '0;
      end
      PH_CAPS_LO: begin
        cap_word |= 32'(b) << (8 * field_cnt[0]);
        field_cnt++;
        if (field_cnt >= 2) begin
          parse_phase = PH_CHARSET_STATUS;
          field_cnt = '0;
        end
      end
      PH_CHARSET_STATUS: begin
        field_cnt++;
        if (field_cnt >= 3) begin
          parse_phase = PH_CAPS_HI;
          field_cnt = '0;
        end
      end
      PH_CAPS_HI: begin
        cap_word |= 32'(b) << (16 + 8 * field_cnt[0]);
        field_cnt++;
        if (field_cnt >= 2) begin
          parse_phase = PH_AUTH_LEN;
          field_cnt = '0;
        end
      end
      PH_AUTH_LEN: begin
        alen = cap_word[ghp_pkg::CAP_PLUGIN_BIT] ? b : 8'd0;
        d = (alen > 8'd8) ? alen - 8'd8 : 8'd0;
        part_two_bytes = (d > PART_TWO_FLOOR) ? d : 8'(PART_TWO_FLOOR);
        parse_phase = PH_RESERVED;
        field_cnt = '0;
      end
      PH_RESERVED: begin
        field_cnt++;
        if (field_cnt >= 10) begin
          field_cnt = '0;
          if (cap_word[ghp_pkg::CAP_SECURE_BIT]) begin
            parse_phase = PH_SCR_TWO;
          end else begin
            parse_phase = cap_word[ghp_pkg::CAP_PLUGIN_BIT] ? PH_PLUGIN : PH_NO_PLUGIN;
          end
        end
      end
      PH_SCR_TWO: begin
        emit_scramble(b);
        field_cnt++;
        if (field_cnt >= part_two_bytes) begin
          field_cnt = '0;
          scr_complete = 1'b1;
          parse_phase = cap_word[ghp_pkg::CAP_PLUGIN_BIT] ? PH_PLUGIN : PH_NO_PLUGIN;
        end
      end
      PH_PLUGIN: begin
        if (b == 8'h00) begin
          parse_phase = PH_PLUGIN_DONE;
        end else if (name_pos < ghp_pkg::NAME_LEN) begin
          if (b == ghp_pkg::PLUGIN_NAME[8 * (ghp_pkg::NAME_LEN - 1 - name_pos) +: 8]) begin
            name_pos++;
          end else begin
            name_intact = 1'b0;
          end
        end else begin
          name_intact = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (item.end_of_packet) begin
      case (parse_phase)
        PH_BAD_VERSION: st = ghp_pkg::STATUS_BAD_VER;
        PH_CHARSET_STATUS: begin
          if (field_cnt == 0) begin
            scr_complete = 1'b1;
            st = ghp_pkg::STATUS_OK;
          end else begin
            st = ghp_pkg::STATUS_TRUNCATED;
          end
        end
        PH_PLUGIN, PH_PLUGIN_DONE:
          st = (name_intact && name_pos == ghp_pkg::NAME_LEN) ?
               ghp_pkg::STATUS_OK : ghp_pkg::STATUS_BAD_PLUG;
        PH_NO_PLUGIN: st = ghp_pkg::STATUS_BAD_PLUG;
        default: st = ghp_pkg::STATUS_TRUNCATED;
      endcase
      byte_results.insert(byte_results.size(),
                          summary(st, version_byte, conn_id, cap_word, scr_complete,
                                  scr_emitted));
      reset_parse();
    end

    if (byte_results.size() > 0) begin
      byte_results[byte_results.size() - 1].run_end = 1'b1;
    end
  endtask

  task automatic send_item(input ghp_pkg::in_req_t item, input logic typed,
                           input ghp_pkg::out_res_t want);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (full);
    parse_greeting_byte(item);
    if (typed) begin
      expected_parse_results.insert(expected_parse_results.size(), want);
    end else begin
      foreach (byte_results[k])
        expected_parse_results.insert(expected_parse_results.size(), byte_results[k]);
    end
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk_i); while (expected_parse_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // write, then read back through the same port
  task automatic set_expected_version(input logic [7:0] value);
    logic [ghp_pkg::CFG_DATA_W-1:0] readback;
    readback = '0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ghp_pkg::CFG_ADDR_W'(4 * ghp_pkg::REG_EXPECTED_VERSION);
    pwdata <= ghp_pkg::CFG_DATA_W'(value);
    for (int rd = 0; rd < 2; rd++) begin
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (rd == 1) readback = prdata;
      @(negedge clk_i);
      penable <= 1'b0;
      pwrite <= 1'b0;
    end
    psel <= 1'b0;
    version_cfg = value;
    if (readback[7:0] !== value) begin
      $display("%0t: expected_version readback expected %0h got %0h", $time, value,
               readback[7:0]);
      mismatch_count++;
    end
  endtask

  task automatic add_byte(input logic [7:0] v);
    packet_bytes.insert(packet_bytes.size(), v);
  endtask

  task automatic build_packet();
    logic [7:0] b;
    logic [7:0] alen;
    logic [7:0] c;
    int caplo_end;
    int two_len;
    int cut;
    int style;
    int name_bytes;
    int bad_pos;
    bit secure;
    bit plugin;
    packet_bytes.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      return;
    end
    add_byte(($urandom_range(99) < 88) ? version_cfg : 8'($urandom));
    repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(1, 255)));
    add_byte(8'h00);
    repeat (14) add_byte(8'($urandom));
    secure = ($urandom_range(99) < 75);
    b = 8'($urandom);
    b[ghp_pkg::CAP_SECURE_BIT - 8] = secure;
    add_byte(b);
    caplo_end = packet_bytes.size();
    repeat (3) add_byte(8'($urandom));
    plugin = ($urandom_range(99) < 70);
    b = 8'($urandom);
    b[ghp_pkg::CAP_PLUGIN_BIT - 16] = plugin;
    add_byte(b);
    add_byte(8'($urandom));
    case ($urandom_range(9))
      0, 1, 2: alen = 8'($urandom_range(0, 8));
      3, 4, 5, 6: alen = 8'($urandom_range(9, 40));
      7: alen = 8'd21;
      default: alen = 8'($urandom);
    endcase
    add_byte(alen);
    repeat (10) add_byte(8'($urandom));
    if (secure) begin
      two_len = (plugin && alen > 8'd21) ? int'(alen) - 8 : int'(PART_TWO_FLOOR);
      repeat (two_len) add_byte(8'($urandom));
    end
    if (plugin) begin
      style = $urandom_range(5);
      name_bytes = (style == 3) ? $urandom_range(0, ghp_pkg::NAME_LEN - 1) :
                                  ghp_pkg::NAME_LEN;
      bad_pos = (style == 2) ? $urandom_range(0, ghp_pkg::NAME_LEN - 1) : -1;
      if (style != 5) begin
        for (int k = 0; k < name_bytes; k++) begin
          c = ghp_pkg::PLUGIN_NAME[8 * (ghp_pkg::NAME_LEN - 1 - k) +: 8];
          if (k == bad_pos) c = c ^ 8'($urandom_range(1, 255));
          add_byte(c);
        end
      end
      if (style == 4) add_byte(8'($urandom_range(1, 255)));
      if (style == 5) repeat ($urandom_range(0, 24)) add_byte(8'($urandom));
      if (style != 1 && style != 5) add_byte(8'h00);
      if (style == 0) repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    end
    case ($urandom_range(9))
      6: cut = caplo_end;
      7, 8, 9: cut = $urandom_range(1, packet_bytes.size());
      default: cut = packet_bytes.size();
    endcase
    while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
  endtask

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    ghp_pkg::out_res_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_parse_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing got %h", $time, res_o);
        mismatch_count++;
      end else begin
        want = expected_parse_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(res_o.kind));
        check_field("scramble_byte", 32'(want.scramble_byte), 32'(res_o.scramble_byte));
        check_field("scramble_index", 32'(want.scramble_index), 32'(res_o.scramble_index));
        check_field("status", 32'(want.status), 32'(res_o.status));
        check_field("version_seen", 32'(want.version_seen), 32'(res_o.version_seen));
        check_field("session_id", want.session_id, res_o.session_id);
        check_field("capabilities", want.capabilities, res_o.capabilities);
        check_field("scramble_ok", 32'(want.scramble_ok), 32'(res_o.scramble_ok));
        check_field("scramble_count", 32'(want.scramble_count), 32'(res_o.scramble_count));
        check_field("run_end", 32'(want.run_end), 32'(res_o.run_end));
      end
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    ghp_pkg::in_req_t item;
    int items;
    int pkts;
    logic [7:0] cfg_value;
    rst_ni = 1'b0;
    push = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_request = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    version_cfg = 8'd10;
    reset_parse();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    rows = '{
      '{'{8'h00, 1'b1}, 1'b1,
        summary(ghp_pkg::STATUS_BAD_VER, 8'h00, 32'h0, 32'h0, 1'b0, 5'd0)},
      '{'{8'hFF, 1'b1}, 1'b1,
        summary(ghp_pkg::STATUS_BAD_VER, 8'hFF, 32'h0, 32'h0, 1'b0, 5'd0)},
      '{'{8'h0A, 1'b1}, 1'b1,
        summary(ghp_pkg::STATUS_TRUNCATED, 8'h0A, 32'h0, 32'h0, 1'b0, 5'd0)},
      '{'{8'h0B, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b1}, 1'b1,
        summary(ghp_pkg::STATUS_BAD_VER, 8'h0B, 32'h0, 32'h0, 1'b0, 5'd0)},
      '{'{8'h0A, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h78, 1'b0}, 1'b0, '0},
      '{'{8'h56, 1'b0}, 1'b0, '0},
      '{'{8'h34, 1'b0}, 1'b0, '0},
      '{'{8'h12, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'h01, 1'b0}, 1'b0, '0},
      '{'{8'h80, 1'b0}, 1'b0, '0},
      '{'{8'h7F, 1'b0}, 1'b0, '0},
      '{'{8'hFE, 1'b0}, 1'b0, '0},
      '{'{8'h55, 1'b0}, 1'b0, '0},
      '{'{8'hAA, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b1}, 1'b1,
        summary(ghp_pkg::STATUS_OK, 8'h0A, 32'h12345678, 32'h0000FFFF, 1'b1, 5'd8)}
    };
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: begin
          cfg_value = 8'd10;
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          cfg_value = 8'h00;
          idle_pct = 51;
          stall_pct = 0;
        end
        2: begin
          cfg_value = 8'hFF;
          idle_pct = 0;
          stall_pct = 51;
        end
        default: begin
          cfg_value = 8'($urandom_range(1, 254));
          idle_pct = 28;
          stall_pct = 28;
        end
      endcase
      set_expected_version(cfg_value);
      items = 0;
      pkts = 0;
      while (items < PHASE_ITEMS) begin
        // hold the receiver off while requests keep coming
        if (ph == 0 && pkts == 1) hold_request = 1'b1;
        build_packet();
        foreach (packet_bytes[i]) begin
          item.data_byte = packet_bytes[i];
          item.end_of_packet = (i == packet_bytes.size() - 1);
          send_item(item, 1'b0, '0);
        end
        items += packet_bytes.size();
        pkts++;
        if (ph == 2 && pkts == 1) drain_results();
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
